FILE: rtl/core/button_click_event_detector_macros.svh
// ----------------------------------------------------------------------------
// Button click event detector - assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BCED_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BCED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define BCED_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bced_pkg.sv
// ----------------------------------------------------------------------------
// Button click event detector - package
// Event codes, register indexes, widths and the front-to-back op record.
// ----------------------------------------------------------------------------
package bced_pkg;

    localparam int TICK_W      = 10;
    localparam int LONG_W      = 32;
    localparam int DCLK_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CODE_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DBL_WINDOW  = 2'd2;

    localparam logic [CODE_W-1:0] EV_DOWN      = 3'd0;
    localparam logic [CODE_W-1:0] EV_UP        = 3'd1;
    localparam logic [CODE_W-1:0] EV_CLICK     = 3'd2;
    localparam logic [CODE_W-1:0] EV_LONG_HOLD = 3'd3;
    localparam logic [CODE_W-1:0] EV_DBL_TAP   = 3'd4;

    typedef enum logic [1:0] {
        OP_DOWN,
        OP_DOUBLE,
        OP_RELEASE
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     click_en;   // single-click mode when the item was classified
    } bced_op_t;

endpackage

FILE: rtl/core/bced_queue.sv
// ----------------------------------------------------------------------------
// Button click event detector - op queue
// Two-entry FIFO between the classifying front and the event back end.
// ----------------------------------------------------------------------------
module bced_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/bced_front.sv
// ----------------------------------------------------------------------------
// Button click event detector - front end
// Takes one level per tick, advances the timers and classifies level changes.
// ----------------------------------------------------------------------------
module bced_front
    import bced_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,      // [0] pin_level
    input  logic [TICK_W-1:0]     tick_period,
    input  logic [DCLK_W-1:0]     dbl_window,
    output logic                  push_valid,
    input  logic                  push_ready,
    output bced_op_t              push_op,
    output logic [TIME_WIDTH-1:0] push_held
);

    // Hold time since the last press; equals clock minus press stamp, modulo
    logic [TIME_WIDTH-1:0] hold_reg, hold_next, hold_inc;
    logic [DCLK_W-1:0]     countdown_reg, countdown_next, countdown_dec;
    logic                  prior_reg, prior_next;
    logic                  level, change, accept;

    assign level    = s_tdata[0];
    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign change   = (level != prior_reg);
    assign hold_inc = hold_reg + TIME_WIDTH'(tick_period);

    always_comb begin
        if (countdown_reg > DCLK_W'(tick_period)) begin
            countdown_dec = countdown_reg - DCLK_W'(tick_period);
        end else begin
            countdown_dec = '0;
        end

        hold_next        = hold_inc;
        countdown_next   = countdown_dec;
        prior_next       = level;
        push_valid       = accept && change;
        push_held        = hold_inc;
        push_op.click_en = (dbl_window == '0);
        push_op.kind     = OP_RELEASE;

        if (change && level) begin
            hold_next = '0;
            if (dbl_window != '0 && countdown_dec != '0) begin
                push_op.kind   = OP_DOUBLE;
                countdown_next = '0;
            end else begin
                push_op.kind   = OP_DOWN;
                countdown_next = dbl_window;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= '0;
            countdown_reg <= '0;
            prior_reg     <= 1'b0;
        end else if (accept) begin
            hold_reg      <= hold_next;
            countdown_reg <= countdown_next;
            prior_reg     <= prior_next;
        end
    end

endmodule

FILE: rtl/core/bced_back.sv
// ----------------------------------------------------------------------------
// Button click event detector - back end
// Turns queued ops into one or two events behind a registered output stage.
// ----------------------------------------------------------------------------
module bced_back
    import bced_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  bced_op_t              op,
    input  logic [TIME_WIDTH-1:0] op_held,
    input  logic [LONG_W-1:0]     hold_limit,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,      // [2:0] event_code
    output logic                  m_tlast       // last_of_run
);

    localparam int CMP_W = (TIME_WIDTH > LONG_W) ? TIME_WIDTH : LONG_W;

    logic              valid_reg, valid_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              last_reg, last_next;
    logic              pend_reg, pend_next;
    logic [CODE_W-1:0] pend_code_reg, pend_code_next;
    logic              out_free, long_hit, has_second;
    logic [CODE_W-1:0] first_code, second_code;

    assign out_free = !valid_reg || m_tready;
    assign op_ready = out_free && !pend_reg;

    assign long_hit = (hold_limit != '0) && (CMP_W'(op_held) > CMP_W'(hold_limit));

    always_comb begin
        first_code  = EV_UP;
        second_code = long_hit ? EV_LONG_HOLD : EV_CLICK;
        has_second  = 1'b0;
        case (op.kind)
            OP_DOWN:    first_code = EV_DOWN;
            OP_DOUBLE:  first_code = EV_DBL_TAP;
            OP_RELEASE: has_second = long_hit || op.click_en;
            default:    first_code = EV_UP;
        endcase
    end

    always_comb begin
        valid_next     = valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_code_next = pend_code_reg;
        if (out_free) begin
            if (pend_reg) begin
                valid_next = 1'b1;
                code_next  = pend_code_reg;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end else if (op_valid) begin
                valid_next     = 1'b1;
                code_next      = first_code;
                last_next      = !has_second;
                pend_next      = has_second;
                pend_code_next = second_code;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
        code_reg      <= code_next;
        last_reg      <= last_next;
        pend_code_reg <= pend_code_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(8-CODE_W){1'b0}}, code_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: rtl/core/button_click_event_detector.sv
// ----------------------------------------------------------------------------
// Button click event detector - top level
// One sampled button level per tick in, down/up/click/long-hold/double-tap
// events out.
//
// Input stream: one item per timer tick, s_tdata[0] is the pin level
// (1 pressed). Ticks with no level change give no event. A press gives one
// event, a release one or two; m_tlast marks the final event of a tick.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 tick period,
// 1 long-press limit, 2 double-click window) at the clock edge; write only
// while the block is idle. Unknown indexes are ignored.
// The first event of a tick is written into the queue when the tick is
// accepted and is then loaded into the output register.
// Throughput: a tick a cycle while the queue has room; the output register
// holds one event at a time, and the back end takes no new op until the
// second event of a release has been loaded.
// Reset (aresetn low, synchronous) clears timers and the queue, sets the
// level to released and restores register defaults. When m_tready is low the
// output item holds, the two-entry queue fills and s_tready then drops.
// ----------------------------------------------------------------------------
module button_click_event_detector
    import bced_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,     // [0] pin_level
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,     // [2:0] event_code
    output logic                   m_tlast,     // last_of_run
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int OP_W = $bits(bced_op_t);
    localparam int Q_W  = TIME_WIDTH + OP_W;

    logic [TICK_W-1:0] tick_period_reg;
    logic [LONG_W-1:0] hold_limit_reg;
    logic [DCLK_W-1:0] dbl_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_W'(1);
            hold_limit_reg  <= LONG_W'(1000);
            dbl_window_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TICK_PERIOD: tick_period_reg <= cfg_wdata[TICK_W-1:0];
                REG_HOLD_LIMIT:  hold_limit_reg  <= cfg_wdata[LONG_W-1:0];
                REG_DBL_WINDOW:  dbl_window_reg  <= cfg_wdata[DCLK_W-1:0];
                default:         ;
            endcase
        end
    end

    logic                  push_valid, push_ready;
    bced_op_t              push_op;
    logic [TIME_WIDTH-1:0] push_held;
    logic                  pop_valid, pop_ready;
    logic [Q_W-1:0]        pop_data;
    bced_op_t              pop_op;
    logic [TIME_WIDTH-1:0] pop_held;

    assign pop_op   = bced_op_t'(pop_data[OP_W-1:0]);
    assign pop_held = pop_data[Q_W-1:OP_W];

    bced_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .tick_period (tick_period_reg),
        .dbl_window  (dbl_window_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_op     (push_op),
        .push_held   (push_held)
    );

    bced_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_held, push_op}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bced_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (pop_valid),
        .op_ready   (pop_ready),
        .op         (pop_op),
        .op_held    (pop_held),
        .hold_limit (hold_limit_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: rtl/core/bced_checker.sv
// ----------------------------------------------------------------------------
// Button click event detector - port checker
// Watches the top-level ports for output stream and event ordering slips.
// ----------------------------------------------------------------------------
`include "button_click_event_detector_macros.svh"

module bced_checker
    import bced_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // stalled output item holds
    `BCED_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // nothing left on the output after reset
    `BCED_ASSERT_NEXT_ANY(a_reset_idle, aclk, !aresetn, !m_tvalid, "output valid straight after reset")

    // only UP can be followed by a second event of the same tick
    `BCED_ASSERT_IMPL(a_last_codes, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[2:0] == EV_UP, "non-final event is not UP")

    // second event of a release follows at once
    `BCED_ASSERT_NEXT(a_second_next, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && (m_tdata[2:0] == EV_LONG_HOLD || m_tdata[2:0] == EV_CLICK), "second release event missing")

endmodule

bind button_click_event_detector bced_checker u_bced_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click event detector - testbench
// Drives sampled pin levels through the tick stream and scores every event
// against an in-bench tracker of the clock, press stamp, level and
// double-click countdown. Runs a directed set, then gesture-shaped random
// ticks under several register settings. Both streams stall at random, apart from one calm run.
// ----------------------------------------------------------------------------
module tb_top;
    import bced_pkg::*;

    localparam int                     TW         = 32;
    localparam int                     CYCLE_CAP  = 400000;
    localparam int                     SETTLE     = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 2'd3;   // not mapped

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } event_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // tracker state and register copies
    logic [TICK_W-1:0] tick_ms     = 10'd1;
    logic [LONG_W-1:0] long_ms     = 32'd1000;
    logic [DCLK_W-1:0] dclk_ms     = '0;
    logic [TW-1:0]     clock_now   = '0;
    logic [TW-1:0]     press_at    = '0;
    logic              level_seen  = 1'b0;
    logic [DCLK_W-1:0] window_left = '0;

    logic   ticks_todo[$];
    event_t events_due[$];

    bit calm = 1'b0;   // no idling on either side
    int cycles = 0;
    int errors = 0;
    int ticks_taken = 0;
    int events_seen = 0;
    int long_seen = 0;
    int double_seen = 0;
    int settings = 0;

    button_click_event_detector #(.TIME_WIDTH(TW)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [0] pin_level
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [2:0] event_code
        .m_tlast   (m_tlast),      // last_of_run
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Advance the tracker by one tick and queue the events it gives
    task automatic track_tick(input logic level);
        logic [TW-1:0] held;
        clock_now = clock_now + TW'(tick_ms);
        if (window_left > DCLK_W'(tick_ms))
            window_left = window_left - DCLK_W'(tick_ms);
        else
            window_left = '0;
        if (level == level_seen)
            return;
        level_seen = level;
        if (level) begin
            press_at = clock_now;
            if (dclk_ms != 0 && window_left != 0) begin
                window_left = '0;
                events_due.push_back('{EV_DBL_TAP, 1'b1});
            end else begin
                window_left = dclk_ms;
                events_due.push_back('{EV_DOWN, 1'b1});
            end
        end else begin
            held = clock_now - press_at;
            if (long_ms != 0 && held > long_ms) begin
                events_due.push_back('{EV_UP, 1'b0});
                events_due.push_back('{EV_LONG_HOLD, 1'b1});
            end else if (dclk_ms == 0) begin
                events_due.push_back('{EV_UP, 1'b0});
                events_due.push_back('{EV_CLICK, 1'b1});
            end else begin
                events_due.push_back('{EV_UP, 1'b1});
            end
        end
    endtask

    // tick driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_tick(s_tdata[0]);
                ticks_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (ticks_todo.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, ticks_todo.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // event monitor
    always @(posedge aclk) begin : event_mon
        event_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    report_mismatch($sformatf("event %0d with none due", m_tdata));
                end else begin
                    due = events_due.pop_front();
                    if (m_tdata !== {{(8 - CODE_W){1'b0}}, due.code})
                        report_mismatch($sformatf("code %0d, wanted %0d", m_tdata, due.code));
                    if (m_tlast !== due.last)
                        report_mismatch($sformatf("tlast %b on code %0d, wanted %b",
                                                  m_tlast, due.code, due.last));
                    events_seen++;
                    if (due.code == EV_LONG_HOLD)
                        long_seen++;
                    if (due.code == EV_DBL_TAP)
                        double_seen++;
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Timed out after %0d cycles, %0d events outstanding",
                     cycles, events_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TICK_PERIOD: tick_ms = val[TICK_W-1:0];
            REG_HOLD_LIMIT:  long_ms = val[LONG_W-1:0];
            REG_DBL_WINDOW:  dclk_ms = val[DCLK_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int tick, input logic [31:0] lim, input int dclk);
        write_reg(REG_TICK_PERIOD, tick);
        write_reg(REG_HOLD_LIMIT, lim);
        write_reg(REG_DBL_WINDOW, dclk);
        settings++;
    endtask

    // wait for the stream to empty and every event to arrive, then let it settle
    task automatic drain;
        @(negedge aclk);
        while (ticks_todo.size() > 0 || s_tvalid || events_due.size() > 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic queue_levels(input logic [31:0] bits, input int n);
        for (int i = 0; i < n; i++)
            ticks_todo.push_back(bits[i]);
    endtask

    // press/release runs with some single-tick noise
    task automatic queue_gestures(input int n, input int hold_max, input int gap_max);
        int added;
        int len;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 15) begin
                ticks_todo.push_back(1'($urandom_range(1)));
                added++;
            end else begin
                len = $urandom_range(1, hold_max);
                repeat (len) ticks_todo.push_back(1'b1);
                added += len;
                len = $urandom_range(1, gap_max);
                repeat (len) ticks_todo.push_back(1'b0);
                added += len;
            end
        end
    endtask

    initial begin : stimulus
        int tick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults: single-click mode; bits are sent lowest first
        queue_levels(32'b011_0110, 7);
        drain();

        // long press with a coarse tick, then a short one
        set_regs(1000, 32'd2500, 0);
        queue_levels(32'b01_0_1111, 7);
        drain();

        // long press disabled, spare register index ignored
        write_reg(REG_HOLD_LIMIT, 32'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        queue_levels(32'b0_1111, 5);
        drain();

        // widest window and limit: double click, then window cleared mid-countdown
        set_regs(1, 32'hFFFF_FFFF, 65535);
        queue_levels(32'b0101_01, 6);
        drain();
        write_reg(REG_DBL_WINDOW, 32'd0);
        queue_levels(32'b01, 2);
        drain();

        // stopped clock
        set_regs(0, 32'd1, 0);
        queue_levels(32'b011, 3);
        drain();

        // random gestures under several settings
        calm = 1'b1;
        set_regs(1, 32'd20, 0);
        queue_gestures(300, 40, 10);
        drain();
        calm = 1'b0;

        set_regs(1000, 32'd4000, 0);
        queue_gestures(250, 8, 6);
        drain();

        set_regs(10, 32'd100, 50);
        queue_gestures(300, 15, 8);
        drain();

        tick = $urandom_range(1, 1000);
        set_regs(tick, tick * $urandom_range(1, 20), tick * $urandom_range(0, 8));
        queue_gestures(300, 25, 12);
        drain();

        set_regs(0, 32'd0, 65535);
        queue_gestures(150, 6, 6);
        drain();

        set_regs(1000, 32'hFFFF_FFFF, 65535);
        queue_gestures(200, 10, 10);
        drain();

        set_regs(3, 32'd1, 1);
        queue_gestures(200, 4, 4);
        drain();

        $display("Covered %0d ticks over %0d register settings plus defaults", ticks_taken,
                 settings);
        $display("Checked %0d events: %0d long presses, %0d double clicks, %0d mismatches",
                 events_seen, long_seen, double_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
